/* rtl/vpp_pkg.sv */
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared constants and types of the vertex perspective projection block.
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int VIEW_WIDTH  = 640;
    localparam int VIEW_HEIGHT = 480;
    localparam int VIEW_BITS   = 16;

    localparam int NREG    = 8;
    localparam int REG_W   = 64;
    localparam int ADDR_W  = 6;
    localparam int ENT_W   = 32;
    localparam int PT_W    = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = ENT_W + PT_W - FRAC_W;
    localparam int CLIP_W  = 50;
    localparam int MAG_W   = CLIP_W;
    localparam int QUO_W   = 36;
    localparam int NDC_W   = QUO_W + 2;
    localparam int DIV_LAT = QUO_W + 2;
    localparam int SCR_W   = 16;
    localparam int SCR_P_W = NDC_W + VIEW_BITS;
    localparam int DEPTH_W = 32;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    typedef logic [NREG-1:0][REG_W-1:0] mat_t;
    typedef logic signed [CLIP_W-1:0] clip_t;

    typedef struct packed {
        logic  behind;
        clip_t x;
        clip_t y;
        clip_t z;
        clip_t w;
    } clip_vec_t;

endpackage

/* rtl/vpp_front.sv */
// ----------------------------------------------------------------------------
// vpp_front
// Matrix transform of one point into clip space, two pipeline stages.
// ----------------------------------------------------------------------------
module vpp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vpp_pkg::mat_t                   mat,
    input  logic                            point_valid,
    output logic                            point_stall,
    input  logic signed [vpp_pkg::PT_W-1:0] point_x,
    input  logic signed [vpp_pkg::PT_W-1:0] point_y,
    input  logic signed [vpp_pkg::PT_W-1:0] point_z,
    output logic                            push,
    output vpp_pkg::clip_vec_t              push_data,
    input  logic                            q_full
);
    import vpp_pkg::*;

    logic signed [PT_W-1:0]   pt [3];
    logic signed [PROD_W-1:0] prod_reg [4][3];
    clip_t                    clip_reg [4];
    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     fe;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    assign fe          = !(s2_valid_reg && q_full);
    assign point_stall = !fe;
    assign push        = s2_valid_reg && !q_full;

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        localparam int RO = r * 2 + 1;
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int RI = r * 2 + c / 2;
            localparam int LO = (c % 2) * ENT_W;
            logic signed [ENT_W+PT_W-1:0] prod;
            assign prod = $signed(mat[RI][LO +: ENT_W]) * pt[c];
            always_ff @(posedge clk)
            begin
                if (fe)
                begin
                    prod_reg[r][c] <= prod[ENT_W+PT_W-1:FRAC_W];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (fe)
            begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                             + CLIP_W'(prod_reg[r][2])
                             + CLIP_W'($signed(mat[RO][2*ENT_W-1:ENT_W]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (fe)
        begin
            s1_valid_reg <= point_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign push_data.behind = (clip_reg[3] <= 0);
    assign push_data.x      = clip_reg[0];
    assign push_data.y      = clip_reg[1];
    assign push_data.z      = clip_reg[2];
    assign push_data.w      = clip_reg[3];

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> (s2_valid_reg && q_full))
        else $error("front stalls with nothing waiting");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && q_full) |=> s2_valid_reg)
        else $error("front dropped a transaction");
`endif

endmodule

/* rtl/vpp_queue.sv */
// ----------------------------------------------------------------------------
// vpp_queue
// Short queue of clip-space points between the front and back parts.
// ----------------------------------------------------------------------------
module vpp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vpp_pkg::clip_vec_t push_data,
    output logic               full,
    input  logic               pop,
    output vpp_pkg::clip_vec_t pop_data,
    output logic               empty
);
    import vpp_pkg::*;

    clip_vec_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overrun or underrun");
`endif

endmodule

/* rtl/vpp_div.sv */
// ----------------------------------------------------------------------------
// vpp_div
// Pipelined restoring divider giving num * 2^16 / den, truncated toward
// zero and clamped to +-2^36, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vpp_div (
    input  logic                             clk,
    input  logic                             en,
    input  vpp_pkg::clip_t                   num,
    input  vpp_pkg::clip_t                   den,
    output logic signed [vpp_pkg::NDC_W-1:0] ndc
);
    import vpp_pkg::*;

    localparam int SH0    = QUO_W - FRAC_W;
    localparam int WRAP_W = 64 - FRAC_W;

    logic [MAG_W-1:0] rem_reg [QUO_W+1];
    logic [MAG_W-1:0] den_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W+1];
    logic [QUO_W-1:0] q_reg   [QUO_W+1];
    logic             neg_reg [QUO_W+1];
    logic             ovf_reg [QUO_W+1];
    logic signed [NDC_W-1:0] ndc_reg;

    logic             neg0;
    logic [MAG_W-1:0] mag0;
    logic [MAG_W-1:0] den0;
    logic [QUO_W:0]   res;

    assign neg0 = num[CLIP_W-1];
    assign mag0 = neg0 ? MAG_W'(-num) : MAG_W'(num);
    assign den0 = MAG_W'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= neg0;
            den_reg[0] <= den0;
            ovf_reg[0] <= (MAG_W'(mag0[MAG_W-1:SH0]) >= den0);
            rem_reg[0] <= MAG_W'(mag0[MAG_W-1:SH0]);
            low_reg[0] <= {mag0[SH0-1:0], {FRAC_W{1'b0}}};
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_stage
        logic [MAG_W-1:0] rin;
        logic [MAG_W:0]   t;
        logic             ge;
        // The first fraction step keeps only the remainder bits that survive
        // a 64-bit left shift by 16.
        if (k == SH0 + 1)
        begin : g_wrap
            assign rin = MAG_W'(rem_reg[k-1][WRAP_W-1:0]);
        end
        else
        begin : g_pass
            assign rin = rem_reg[k-1];
        end
        assign t  = {rin, low_reg[k-1][QUO_W-1]};
        assign ge = (t >= {1'b0, den_reg[k-1]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? MAG_W'(t - {1'b0, den_reg[k-1]}) : MAG_W'(t);
                low_reg[k] <= {low_reg[k-1][QUO_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QUO_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign res = ovf_reg[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, q_reg[QUO_W]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ndc_reg <= neg_reg[QUO_W] ? -$signed({1'b0, res}) : $signed({1'b0, res});
        end
    end

    assign ndc = ndc_reg;

endmodule

/* rtl/vpp_back.sv */
// ----------------------------------------------------------------------------
// vpp_back
// Perspective divide, viewport mapping and frustum test with the output
// register.
// ----------------------------------------------------------------------------
module vpp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vpp_pkg::clip_vec_t                 pop_data,
    input  logic                               empty,
    output logic                               pop,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               behind_camera,
    output logic signed [vpp_pkg::SCR_W-1:0]   screen_x,
    output logic signed [vpp_pkg::SCR_W-1:0]   screen_y,
    output logic signed [vpp_pkg::DEPTH_W-1:0] depth_ndc,
    output logic                               inside_frustum
);
    import vpp_pkg::*;

    localparam logic signed [NDC_W-1:0]   ONE  = NDC_W'(1 << FRAC_W);
    localparam logic signed [SCR_P_W-1:0] VW_S = SCR_P_W'(VIEW_WIDTH);
    localparam logic signed [SCR_P_W-1:0] VH_S = SCR_P_W'(VIEW_HEIGHT);
    localparam logic signed [SCR_P_W-1:0] RND  = SCR_P_W'((1 << (FRAC_W + 1)) - 1);
    localparam logic signed [NDC_W-1:0]   DMAX = NDC_W'(64'sh7FFFFFFF);
    localparam logic signed [NDC_W-1:0]   DMIN = -NDC_W'(64'sh80000000);

    function automatic logic signed [SCR_W-1:0] scr_sat(input logic signed [SCR_P_W-1:0] p);
        logic signed [SCR_P_W-1:0] adj;
        logic signed [SCR_P_W-1:0] q;
        adj = p[SCR_P_W-1] ? p + RND : p;
        q   = adj >>> (FRAC_W + 1);
        if (q > SCR_P_W'(32767))
            scr_sat = SCR_W'(32767);
        else if (q < -SCR_P_W'(32768))
            scr_sat = SCR_W'(-32768);
        else
            scr_sat = q[SCR_W-1:0];
    endfunction

    logic                    be;
    logic                    vld_reg [DIV_LAT];
    logic                    beh_reg [DIV_LAT];
    logic signed [NDC_W-1:0] nx, ny, nz;
    logic signed [NDC_W-1:0] sxa, sya;

    logic                      pa_valid_reg;
    logic                      pa_behind_reg;
    logic signed [SCR_P_W-1:0] sxp_reg, syp_reg;
    logic                      pa_inside_reg;
    logic signed [DEPTH_W-1:0] pa_depth_reg;

    logic                      res_valid_reg;
    logic                      behind_reg;
    logic signed [SCR_W-1:0]   sx_reg, sy_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic                      inside_reg;

    assign be  = !res_valid_reg || !result_stall;
    assign pop = be && !empty;

    vpp_div u_div_x (.clk(clk), .en(be), .num(pop_data.x), .den(pop_data.w), .ndc(nx));
    vpp_div u_div_y (.clk(clk), .en(be), .num(pop_data.y), .den(pop_data.w), .ndc(ny));
    vpp_div u_div_z (.clk(clk), .en(be), .num(pop_data.z), .den(pop_data.w), .ndc(nz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            pa_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (be)
        begin
            vld_reg[0] <= pop;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            pa_valid_reg  <= vld_reg[DIV_LAT-1];
            res_valid_reg <= pa_valid_reg;
        end
    end

    assign sxa = nx + ONE;
    assign sya = ONE - ny;

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            beh_reg[0] <= pop_data.behind;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                beh_reg[i] <= beh_reg[i-1];
            end
            pa_behind_reg <= beh_reg[DIV_LAT-1];
            sxp_reg       <= SCR_P_W'(sxa) * VW_S;
            syp_reg       <= SCR_P_W'(sya) * VH_S;
            pa_inside_reg <= (nx >= -ONE) && (nx <= ONE) && (ny >= -ONE) && (ny <= ONE)
                          && (nz >= -ONE) && (nz <= ONE);
            if (nz > DMAX)
                pa_depth_reg <= DEPTH_W'(DMAX);
            else if (nz < DMIN)
                pa_depth_reg <= DEPTH_W'(DMIN);
            else
                pa_depth_reg <= nz[DEPTH_W-1:0];
            behind_reg <= pa_behind_reg;
            sx_reg     <= pa_behind_reg ? '0 : scr_sat(sxp_reg);
            sy_reg     <= pa_behind_reg ? '0 : scr_sat(syp_reg);
            depth_reg  <= pa_behind_reg ? '0 : pa_depth_reg;
            inside_reg <= pa_behind_reg ? 1'b0 : pa_inside_reg;
        end
    end

    assign result_valid   = res_valid_reg;
    assign behind_camera  = behind_reg;
    assign screen_x       = sx_reg;
    assign screen_y       = sy_reg;
    assign depth_ndc      = depth_reg;
    assign inside_frustum = inside_reg;

`ifndef NO_ASSERTIONS
    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && behind_camera) |-> (screen_x == 0 && screen_y == 0
            && depth_ndc == 0 && !inside_frustum))
        else $error("behind-camera transaction carries nonzero fields");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(depth_ndc)))
        else $error("stalled result changed");
`endif

endmodule

/* rtl/vertex_perspective_project_core.sv */
// ----------------------------------------------------------------------------
// vertex_perspective_project_core
// Projects Q16.16 points through a 4x4 matrix onto a screen.
// ----------------------------------------------------------------------------
// The block takes one point per clock while point_stall is low and gives
// one result per point in order. A point passes the transform stages (one
// bank of twelve 32x32 multipliers, then the row sums), a four-entry queue,
// and then forty register stages in the back part, set by the three 38-stage
// restoring dividers, the viewport multipliers and the output register.
// Matrix registers sit at byte addresses 8*i and are to be written only while
// no transaction is in flight; the block itself does not enforce this.
module vertex_perspective_project_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [vpp_pkg::ADDR_W-1:0]           paddr,
    input  logic [vpp_pkg::REG_W-1:0]            pwdata,
    output logic [vpp_pkg::REG_W-1:0]            prdata,
    output logic                                 pready,
    input  logic                                 point_valid,
    output logic                                 point_stall,
    input  logic signed [vpp_pkg::PT_W-1:0]      point_x,
    input  logic signed [vpp_pkg::PT_W-1:0]      point_y,
    input  logic signed [vpp_pkg::PT_W-1:0]      point_z,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic                                 behind_camera,
    output logic signed [vpp_pkg::SCR_W-1:0]     screen_x,
    output logic signed [vpp_pkg::SCR_W-1:0]     screen_y,
    output logic signed [vpp_pkg::DEPTH_W-1:0]   depth_ndc,
    output logic                                 inside_frustum
);
    import vpp_pkg::*;

    mat_t      mat_reg;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    clip_vec_t push_data;
    clip_vec_t pop_data;

    assign pready = 1'b1;
    assign prdata = mat_reg[paddr[ADDR_W-1:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            mat_reg[paddr[ADDR_W-1:3]] <= pwdata;
        end
    end

    vpp_front u_front (
        .clk(clk), .rst_n(rst_n), .mat(mat_reg),
        .point_valid(point_valid), .point_stall(point_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .push(push), .push_data(push_data), .q_full(q_full)
    );

    vpp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
        .pop(pop), .pop_data(pop_data), .empty(q_empty)
    );

    vpp_back u_back (
        .clk(clk), .rst_n(rst_n), .pop_data(pop_data), .empty(q_empty), .pop(pop),
        .result_valid(result_valid), .result_stall(result_stall),
        .behind_camera(behind_camera), .screen_x(screen_x), .screen_y(screen_y),
        .depth_ndc(depth_ndc), .inside_frustum(inside_frustum)
    );

endmodule
